FILE: rtl/core/thm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thm_pkg
// Shared types, register indexes and fixed-point constants of the
// thermistor frame to temperature pipeline.
// ----------------------------------------------------------------------------
package thm_pkg;

  // Result classification carried with every beat
  typedef enum logic [1:0] {
    ST_VALID    = 2'd0,
    ST_LOW      = 2'd1,
    ST_DETACHED = 2'd2
  } status_t;

  // Side band that travels with the data through every stage
  typedef struct packed {
    logic        vld;
    status_t     st;
    logic [14:0] code;
  } meta_t;

  // Configuration register file as seen by the datapath
  typedef struct packed {
    logic [31:0] coeff_a;
    logic [31:0] coeff_b;
    logic [31:0] coeff_c;
    logic [15:0] ref_ohm;
    logic [15:0] thr_ohm;
  } cfg_t;

  // Register indexes
  localparam logic [2:0] CFG_COEFF_A = 3'd0;
  localparam logic [2:0] CFG_COEFF_B = 3'd1;
  localparam logic [2:0] CFG_COEFF_C = 3'd2;
  localparam logic [2:0] CFG_REF_OHM = 3'd3;
  localparam logic [2:0] CFG_THR_OHM = 3'd4;

  // Register reset values
  localparam logic [31:0] RST_COEFF_A = 32'd1334911865;
  localparam logic [31:0] RST_COEFF_B = 32'd258545046;
  localparam logic [31:0] RST_COEFF_C = 32'd100075;
  localparam logic [15:0] RST_REF_OHM = 16'd10000;
  localparam logic [15:0] RST_THR_OHM = 16'd100;

  // Status byte checks
  localparam logic [7:0] STAT_PATTERN = 8'h0D;
  localparam int         STAT_BAD_BIT = 7;

  // Fixed-point formats
  localparam int LOG_FRAC_BITS = 30;           // fraction bits of log2 R
  localparam int LN_BITS       = 30;           // ln R, Q4.26 (value < 12)
  localparam int D_BITS        = 45;           // Steinhart-Hart denominator
  localparam int QUO_BITS      = 17;           // quotient bits kept
  localparam logic [29:0] LN2_Q30 = 30'd744261118;
  // floor(100 * 2^40 / 2^17): a denominator at or below this overflows
  localparam logic [44:0] DIV_REM0 = 45'd838860800;
  localparam logic [16:0] KELVIN_CENTI = 17'd27315;
  localparam logic [15:0] TEMP_MAX = 16'hFFFF;

  // Stage counts of the pipeline parts
  localparam int FRONT_LAT = 3;
  localparam int LOG_LAT   = LOG_FRAC_BITS + 1;
  localparam int POLY_LAT  = 4;
  localparam int DIV_LAT   = QUO_BITS + 2;

endpackage

FILE: rtl/core/thm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thm_front
// Captures a frame, scales the code to ohms, classifies faults and
// normalizes the resistance for the logarithm.
// ----------------------------------------------------------------------------
module thm_front #(
  parameter int ADC_CODE_BITS = 15
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  logic [23:0]         frame,
  input  thm_pkg::cfg_t       cfg,
  output thm_pkg::meta_t      meta,
  output logic [31:0]         mant,
  output logic [3:0]          expo
);

  localparam logic [31:0] FULL = (32'd1 << ADC_CODE_BITS) - 32'd1;

  logic [ADC_CODE_BITS-1:0] code;
  thm_pkg::meta_t s1_meta, s2_meta;
  logic [31:0]    s1_prod;
  logic [15:0]    s2_r;
  logic [15:0]    r_next;
  thm_pkg::status_t st_next;
  logic [3:0]     n_next;

  assign code = frame[8 +: ADC_CODE_BITS];

  // Stage 1: capture and multiply code by the reference
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_meta.vld <= 1'b0;
    end else begin
      s1_meta.vld <= take;
    end
    s1_meta.st   <= (frame[7:0] == thm_pkg::STAT_PATTERN) ? thm_pkg::ST_VALID
                                                          : thm_pkg::ST_DETACHED;
    s1_meta.code <= 15'(code);
    s1_prod      <= 32'(code) * 32'(cfg.ref_ohm);
  end

  // Divide by 2^N - 1: fold high digits onto low ones, then one correction
  always_comb begin
    logic [31:0] s;
    logic [31:0] q;
    s = s1_prod;
    q = 32'd0;
    for (int i = 0; i < 4; i++) begin
      q = q + (s >> ADC_CODE_BITS);
      s = (s >> ADC_CODE_BITS) + (s & FULL);
    end
    if (s >= FULL) begin
      q = q + 32'd1;
    end
    r_next = q[15:0];
  end

  // Flag a short or zero resistance
  always_comb begin
    st_next = s1_meta.st;
    if (s1_meta.st == thm_pkg::ST_VALID &&
        (r_next < cfg.thr_ohm || r_next == 16'd0)) begin
      st_next = thm_pkg::ST_LOW;
    end
  end

  // Stage 2: resistance and class
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_meta.vld <= 1'b0;
    end else begin
      s2_meta.vld <= s1_meta.vld;
    end
    s2_meta.st   <= st_next;
    s2_meta.code <= s1_meta.code;
    s2_r         <= r_next;
  end

  // Find the leading one of the resistance
  always_comb begin
    n_next = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (s2_r[i]) begin
        n_next = 4'(i);
      end
    end
  end

  // Stage 3: exponent and Q1.31 mantissa
  always_ff @(posedge clk) begin
    if (rst) begin
      meta.vld <= 1'b0;
    end else begin
      meta.vld <= s2_meta.vld;
    end
    meta.st   <= s2_meta.st;
    meta.code <= s2_meta.code;
    expo      <= n_next;
    mant      <= {s2_r, 16'h0000} << (4'd15 - n_next);
  end

endmodule

FILE: rtl/core/thm_log.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thm_log
// Natural logarithm: one squaring stage per fraction bit of log2, then a
// scale by ln 2 into Q4.26.
// ----------------------------------------------------------------------------
module thm_log (
  input  logic                 clk,
  input  logic                 rst,
  input  thm_pkg::meta_t       in_meta,
  input  logic [31:0]          in_mant,
  input  logic [3:0]           in_expo,
  output thm_pkg::meta_t       meta,
  output logic [thm_pkg::LN_BITS-1:0] ln
);

  localparam int NF = thm_pkg::LOG_FRAC_BITS;

  thm_pkg::meta_t sq_meta [NF+1];
  logic [31:0]    sq_m    [NF+1];
  logic [NF-1:0]  sq_frac [NF+1];
  logic [3:0]     sq_n    [NF+1];
  logic [63:0]    ln_prod;

  assign sq_meta[0] = in_meta;
  assign sq_m[0]    = in_mant;
  assign sq_frac[0] = '0;
  assign sq_n[0]    = in_expo;

  // Square the mantissa; an overflow past 2.0 yields the next fraction bit
  for (genvar g = 0; g < NF; g++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] hi;
    assign sq = 64'(sq_m[g]) * 64'(sq_m[g]);
    assign hi = sq[63:31];
    always_ff @(posedge clk) begin
      if (rst) begin
        sq_meta[g+1].vld <= 1'b0;
      end else begin
        sq_meta[g+1].vld <= sq_meta[g].vld;
      end
      sq_meta[g+1].st   <= sq_meta[g].st;
      sq_meta[g+1].code <= sq_meta[g].code;
      sq_m[g+1]         <= hi[32] ? hi[32:1] : hi[31:0];
      sq_frac[g+1]      <= {sq_frac[g][NF-2:0], hi[32]};
      sq_n[g+1]         <= sq_n[g];
    end
  end

  // Convert log2 to ln
  assign ln_prod = 64'({sq_n[NF], sq_frac[NF]}) * 64'(thm_pkg::LN2_Q30);

  always_ff @(posedge clk) begin
    if (rst) begin
      meta.vld <= 1'b0;
    end else begin
      meta.vld <= sq_meta[NF].vld;
    end
    meta.st   <= sq_meta[NF].st;
    meta.code <= sq_meta[NF].code;
    ln        <= ln_prod[63:34];
  end

endmodule

FILE: rtl/core/thm_poly.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thm_poly
// Steinhart-Hart denominator A + B ln R + C (ln R)^3 on the 2^40 scale.
// ----------------------------------------------------------------------------
module thm_poly (
  input  logic                          clk,
  input  logic                          rst,
  input  thm_pkg::meta_t                in_meta,
  input  logic [thm_pkg::LN_BITS-1:0]   in_ln,
  input  thm_pkg::cfg_t                 cfg,
  output thm_pkg::meta_t                meta,
  output logic [thm_pkg::D_BITS-1:0]    d
);

  thm_pkg::meta_t a_meta, b_meta, c_meta;
  logic [thm_pkg::LN_BITS-1:0] a_ln;
  logic [33:0] a_sq;
  logic [35:0] a_bt, b_bt, c_bt;
  logic [37:0] b_cu;
  logic [43:0] c_hi;
  logic [57:0] c_lo;
  logic [63:0] sq_p, bt_p, cu_p;

  assign sq_p = 64'(in_ln) * 64'(in_ln);
  assign bt_p = 64'(cfg.coeff_b) * 64'(in_ln);
  assign cu_p = 64'(a_sq) * 64'(a_ln);

  // Stage A: square and B term
  always_ff @(posedge clk) begin
    if (rst) begin
      a_meta.vld <= 1'b0;
    end else begin
      a_meta.vld <= in_meta.vld;
    end
    a_meta.st   <= in_meta.st;
    a_meta.code <= in_meta.code;
    a_ln        <= in_ln;
    a_sq        <= sq_p[59:26];
    a_bt        <= bt_p[61:26];
  end

  // Stage B: cube
  always_ff @(posedge clk) begin
    if (rst) begin
      b_meta.vld <= 1'b0;
    end else begin
      b_meta.vld <= a_meta.vld;
    end
    b_meta.st   <= a_meta.st;
    b_meta.code <= a_meta.code;
    b_cu        <= cu_p[63:26];
    b_bt        <= a_bt;
  end

  // Stage C: C term as integer and fraction parts of the cube
  always_ff @(posedge clk) begin
    if (rst) begin
      c_meta.vld <= 1'b0;
    end else begin
      c_meta.vld <= b_meta.vld;
    end
    c_meta.st   <= b_meta.st;
    c_meta.code <= b_meta.code;
    c_hi        <= 44'(cfg.coeff_c) * 44'(b_cu[37:26]);
    c_lo        <= 58'(cfg.coeff_c) * 58'(b_cu[25:0]);
    c_bt        <= b_bt;
  end

  // Stage D: sum the three terms
  always_ff @(posedge clk) begin
    if (rst) begin
      meta.vld <= 1'b0;
    end else begin
      meta.vld <= c_meta.vld;
    end
    meta.st   <= c_meta.st;
    meta.code <= c_meta.code;
    d         <= 45'(cfg.coeff_a) + 45'(c_bt) + 45'(c_hi) + 45'(c_lo[57:26]);
  end

endmodule

FILE: rtl/core/thm_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thm_div
// Restoring divider for 100 * 2^40 / D, one quotient bit per stage, then
// the Kelvin offset, clamping and the fault codes.
// ----------------------------------------------------------------------------
module thm_div (
  input  logic                        clk,
  input  logic                        rst,
  input  thm_pkg::meta_t              in_meta,
  input  logic [thm_pkg::D_BITS-1:0]  in_d,
  output logic                        out_vld,
  output logic [15:0]                 out_temp,
  output logic [1:0]                  out_status,
  output logic [14:0]                 out_code
);

  localparam int NQ = thm_pkg::QUO_BITS;
  localparam int DW = thm_pkg::D_BITS;

  thm_pkg::meta_t dv_meta [NQ+1];
  logic [DW-1:0]  dv_d    [NQ+1];
  logic [DW-1:0]  dv_rem  [NQ+1];
  logic [NQ-1:0]  dv_q    [NQ+1];
  logic           dv_ovf  [NQ+1];
  logic [16:0]    q_fin;
  logic [15:0]    temp_next;

  // Stage 0: overflow check; the high numerator bits seed the remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      dv_meta[0].vld <= 1'b0;
    end else begin
      dv_meta[0].vld <= in_meta.vld;
    end
    dv_meta[0].st   <= in_meta.st;
    dv_meta[0].code <= in_meta.code;
    dv_d[0]         <= in_d;
    dv_rem[0]       <= thm_pkg::DIV_REM0;
    dv_q[0]         <= '0;
    dv_ovf[0]       <= (in_d <= thm_pkg::DIV_REM0);
  end

  // One quotient bit per stage; the numerator below bit 17 is all zero
  for (genvar g = 0; g < NQ; g++) begin : g_div
    logic [DW:0] rem2;
    logic        ge;
    assign rem2 = {dv_rem[g], 1'b0};
    assign ge   = (rem2 >= {1'b0, dv_d[g]});
    always_ff @(posedge clk) begin
      if (rst) begin
        dv_meta[g+1].vld <= 1'b0;
      end else begin
        dv_meta[g+1].vld <= dv_meta[g].vld;
      end
      dv_meta[g+1].st   <= dv_meta[g].st;
      dv_meta[g+1].code <= dv_meta[g].code;
      dv_d[g+1]         <= dv_d[g];
      dv_rem[g+1]       <= ge ? DW'(rem2 - {1'b0, dv_d[g]}) : DW'(rem2);
      dv_q[g+1]         <= {dv_q[g][NQ-2:0], ge};
      dv_ovf[g+1]       <= dv_ovf[g];
    end
  end

  assign q_fin = 17'(dv_q[NQ]);

  // Offset to Celsius, clamp, and substitute fault codes
  always_comb begin
    case (dv_meta[NQ].st)
      thm_pkg::ST_DETACHED: temp_next = 16'd1;
      thm_pkg::ST_LOW:      temp_next = 16'd0;
      default: begin
        if (dv_ovf[NQ]) begin
          temp_next = thm_pkg::TEMP_MAX;
        end else if (q_fin < thm_pkg::KELVIN_CENTI) begin
          temp_next = 16'd0;
        end else if ((q_fin - thm_pkg::KELVIN_CENTI) > 17'(thm_pkg::TEMP_MAX)) begin
          temp_next = thm_pkg::TEMP_MAX;
        end else begin
          temp_next = 16'(q_fin - thm_pkg::KELVIN_CENTI);
        end
      end
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else begin
      out_vld <= dv_meta[NQ].vld;
    end
    out_temp   <= temp_next;
    out_status <= 2'(dv_meta[NQ].st);
    out_code   <= dv_meta[NQ].code;
  end

endmodule

FILE: rtl/core/thermistor_frame_to_temperature_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermistor_frame_to_temperature_top
// Converts converter frames into Steinhart-Hart temperatures.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive adc_frame with start high; the frame is taken on a
//   rising edge where busy is low. busy is high only during reset, so a new
//   frame may be issued every cycle.
//   Frames whose status byte fails the 01101 / bit 7 check are dropped and
//   give no result. Every other frame gives one result at the pipeline end:
//   result_valid is high for one cycle with temp_centi_c, status and
//   adc_code. Throughput is one frame per cycle. The pipeline holds 3 front
//   stages, 30 squaring stages plus one ln 2 scaling stage for the logarithm,
//   4 polynomial stages and 19 divider stages (17 of them one-bit steps).
//   The receiver cannot stall, so results are never held back.
//   Configuration: write cfg_data to register cfg_index while cfg_valid is
//   high; cfg_ready is always high. Write only while no frame is in flight.
//   Reset (rst, synchronous) empties the pipeline and loads the default
//   coefficients, reference and threshold.
// ----------------------------------------------------------------------------
module thermistor_frame_to_temperature_top #(
  parameter int ADC_CODE_BITS = 15
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [23:0] adc_frame,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic        result_valid,
  output logic [15:0] temp_centi_c,
  output logic [1:0]  status,
  output logic [14:0] adc_code
);

  localparam int LAT = thm_pkg::FRONT_LAT + thm_pkg::LOG_LAT +
                       thm_pkg::POLY_LAT + thm_pkg::DIV_LAT;

  thm_pkg::cfg_t  cfg;
  thm_pkg::meta_t fr_meta, lg_meta, pl_meta;
  logic [31:0]    fr_mant;
  logic [3:0]     fr_expo;
  logic [thm_pkg::LN_BITS-1:0] lg_ln;
  logic [thm_pkg::D_BITS-1:0]  pl_d;
  logic           frame_ok;
  logic           take;

  assign busy      = rst;
  assign cfg_ready = 1'b1;

  // Keep frames with the expected low status bits and bit 7 clear
  assign frame_ok = (adc_frame[4:0] == thm_pkg::STAT_PATTERN[4:0]) &&
                    !adc_frame[thm_pkg::STAT_BAD_BIT];
  assign take     = start && !busy && frame_ok;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.coeff_a <= thm_pkg::RST_COEFF_A;
      cfg.coeff_b <= thm_pkg::RST_COEFF_B;
      cfg.coeff_c <= thm_pkg::RST_COEFF_C;
      cfg.ref_ohm <= thm_pkg::RST_REF_OHM;
      cfg.thr_ohm <= thm_pkg::RST_THR_OHM;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        thm_pkg::CFG_COEFF_A: cfg.coeff_a <= cfg_data;
        thm_pkg::CFG_COEFF_B: cfg.coeff_b <= cfg_data;
        thm_pkg::CFG_COEFF_C: cfg.coeff_c <= cfg_data;
        thm_pkg::CFG_REF_OHM: cfg.ref_ohm <= cfg_data[15:0];
        thm_pkg::CFG_THR_OHM: cfg.thr_ohm <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  thm_front #(
    .ADC_CODE_BITS (ADC_CODE_BITS)
  ) u_front (
    .clk   (clk),
    .rst   (rst),
    .take  (take),
    .frame (adc_frame),
    .cfg   (cfg),
    .meta  (fr_meta),
    .mant  (fr_mant),
    .expo  (fr_expo)
  );

  thm_log u_log (
    .clk     (clk),
    .rst     (rst),
    .in_meta (fr_meta),
    .in_mant (fr_mant),
    .in_expo (fr_expo),
    .meta    (lg_meta),
    .ln      (lg_ln)
  );

  thm_poly u_poly (
    .clk     (clk),
    .rst     (rst),
    .in_meta (lg_meta),
    .in_ln   (lg_ln),
    .cfg     (cfg),
    .meta    (pl_meta),
    .d       (pl_d)
  );

  thm_div u_div (
    .clk        (clk),
    .rst        (rst),
    .in_meta    (pl_meta),
    .in_d       (pl_d),
    .out_vld    (result_valid),
    .out_temp   (temp_centi_c),
    .out_status (status),
    .out_code   (adc_code)
  );

  // Every result traces back to a kept frame
  a_result_has_frame: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(take, LAT))
    else $error("result without a kept frame");

  // The reported code is the one taken from that frame
  a_code_matches: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> adc_code == 15'($past(adc_frame[8 +: ADC_CODE_BITS], LAT)))
    else $error("result code does not match its frame");

  // Fault classes carry their fixed temperature codes
  a_fault_codes: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == 2'(thm_pkg::ST_DETACHED) |-> temp_centi_c == 16'd1)
    else $error("detached result with wrong temperature code");

  a_low_codes: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == 2'(thm_pkg::ST_LOW) |-> temp_centi_c == 16'd0)
    else $error("low resistance result with wrong temperature code");

endmodule
